### rtl/ptmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmu_pkg
// Shared constants, status codes and the result item layout for the
// two-level page table updater.
// ----------------------------------------------------------------------------
package ptmu_pkg;

	// Address split: 10-bit directory index, 10-bit table index, 12-bit offset
	localparam int unsigned PAGE_OFS_W = 12;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned FRAME_W    = 20;
	localparam int unsigned ENTRY_W    = 32;
	localparam int unsigned TBL_ENTRIES = 1024;

	// Entry flags: present and writable
	localparam logic [ENTRY_W-1:0] ENTRY_FLAGS = 32'h0000_0003;
	// Directory entry after reset: writable, not present
	localparam logic [ENTRY_W-1:0] DIR_RESET   = 32'h0000_0002;
	localparam logic [FRAME_W-1:0] TAF_RESET   = 20'd256;

	localparam int unsigned NUM_TABLES_DEF = 16;

	// Stream widths
	localparam int unsigned S_TDATA_W = 64;
	localparam int unsigned S_TUSER_W = 1;
	localparam int unsigned M_TDATA_W = 48;

	// Request kinds
	localparam logic FUNC_MAP   = 1'b0;
	localparam logic FUNC_UNMAP = 1'b1;

	// Status codes
	localparam logic [2:0] STATUS_OK          = 3'd0;
	localparam logic [2:0] STATUS_VA_UNALIGN  = 3'd1;
	localparam logic [2:0] STATUS_PA_UNALIGN  = 3'd2;
	localparam logic [2:0] STATUS_NO_DIR      = 3'd3;
	localparam logic [2:0] STATUS_NOT_MAPPED  = 3'd4;
	localparam logic [2:0] STATUS_EXHAUSTED   = 3'd5;

	// Result item, last field in the lowest bits
	typedef struct packed {
		logic [1:0]         pad;
		logic [ENTRY_W-1:0] entry_value;
		logic [IDX_W-1:0]   directory_index;
		logic               table_allocated;
		logic [2:0]         status;
	} result_t;

endpackage

### rtl/ptmu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmu_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module ptmu_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10,
	parameter int unsigned DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write and read; read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/ptmu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmu_ctrl
// Request sequencer: reads the directory, claims tables, reads or writes the
// table entry, clears both memories after reset and holds the result item.
// ----------------------------------------------------------------------------
module ptmu_ctrl #(
	parameter int unsigned NUM_TABLES = ptmu_pkg::NUM_TABLES_DEF,
	parameter int unsigned SLOT_W     = 4,
	parameter int unsigned TBL_AW     = 14,
	parameter int unsigned CNT_W      = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ptmu_pkg::S_TUSER_W-1:0]       s_tuser,
	input  logic [ptmu_pkg::S_TDATA_W-1:0]       s_tdata,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ptmu_pkg::M_TDATA_W-1:0]       m_tdata,
	// table area register
	input  logic                                 cfg_we,
	input  logic [ptmu_pkg::FRAME_W-1:0]         cfg_wdata,
	// directory memory
	output logic                                 dir_we,
	output logic [ptmu_pkg::IDX_W-1:0]           dir_waddr,
	output logic [ptmu_pkg::ENTRY_W-1:0]         dir_wdata,
	output logic                                 dir_re,
	output logic [ptmu_pkg::IDX_W-1:0]           dir_raddr,
	input  logic [ptmu_pkg::ENTRY_W-1:0]         dir_rdata,
	// table memory
	output logic                                 tbl_we,
	output logic [TBL_AW-1:0]                    tbl_waddr,
	output logic [ptmu_pkg::ENTRY_W-1:0]         tbl_wdata,
	output logic                                 tbl_re,
	output logic [TBL_AW-1:0]                    tbl_raddr,
	input  logic [ptmu_pkg::ENTRY_W-1:0]         tbl_rdata
);

	localparam int unsigned FW = ptmu_pkg::FRAME_W;
	localparam int unsigned OW = ptmu_pkg::PAGE_OFS_W;
	localparam int unsigned IW = ptmu_pkg::IDX_W;
	localparam int unsigned EW = ptmu_pkg::ENTRY_W;
	localparam int unsigned CLR_LAST = NUM_TABLES * ptmu_pkg::TBL_ENTRIES - 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIR  = 2'd1;
	localparam logic [1:0] S_TBL  = 2'd2;

	logic [1:0]        state_q;
	logic              clr_q;
	logic [TBL_AW-1:0] clr_cnt_q;
	logic [FW-1:0]     taf_q;
	logic [CNT_W-1:0]  used_q;
	logic              func_q;
	logic [EW-1:0]     va_q;
	logic [EW-1:0]     pa_q;
	logic [TBL_AW-1:0] tbl_addr_q;
	logic              out_valid_q;
	ptmu_pkg::result_t out_q;

	logic              accept;
	logic              out_free;
	logic              va_bad;
	logic              pa_bad;
	logic              present;
	logic              exhausted;
	logic [FW-1:0]     new_frame;
	logic [EW-1:0]     new_pde;
	logic [EW-1:0]     eff_pde;
	logic [FW-1:0]     slot_diff;
	logic              slot_ok;
	logic [TBL_AW-1:0] tbl_addr;
	logic              clr_dir;

	logic              finish;
	logic              go_tbl;
	logic              claim;
	ptmu_pkg::result_t res;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && !clr_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// Decode the directory entry of the held request
	assign va_bad    = |va_q[OW-1:0];
	assign pa_bad    = |pa_q[OW-1:0];
	assign present   = dir_rdata[0];
	assign exhausted = (used_q == CNT_W'(NUM_TABLES));
	assign new_frame = taf_q + FW'(used_q);
	assign new_pde   = {new_frame, OW'(0)} | ptmu_pkg::ENTRY_FLAGS;
	assign eff_pde   = present ? dir_rdata : new_pde;
	assign slot_diff = eff_pde[EW-1:OW] - taf_q;
	assign slot_ok   = (slot_diff < FW'(NUM_TABLES));
	assign tbl_addr  = {slot_diff[SLOT_W-1:0], va_q[OW+IW-1:OW]};
	assign clr_dir   = (clr_cnt_q[TBL_AW-1:IW] == '0);

	// Work out the step, the result and the memory accesses
	always_comb begin
		finish                = 1'b0;
		go_tbl                = 1'b0;
		claim                 = 1'b0;
		res                   = '0;
		res.directory_index   = va_q[EW-1:EW-IW];
		dir_re                = accept;
		dir_raddr             = s_tdata[EW-1:EW-IW];
		dir_we                = 1'b0;
		dir_waddr             = va_q[EW-1:EW-IW];
		dir_wdata             = new_pde;
		tbl_re                = 1'b0;
		tbl_raddr             = tbl_addr;
		tbl_we                = 1'b0;
		tbl_waddr             = tbl_addr;
		tbl_wdata             = pa_q | ptmu_pkg::ENTRY_FLAGS;
		unique case (state_q)
			S_IDLE: begin
				// clear both memories after reset
				if (clr_q) begin
					tbl_we    = 1'b1;
					tbl_waddr = clr_cnt_q;
					tbl_wdata = '0;
					dir_we    = clr_dir;
					dir_waddr = clr_cnt_q[IW-1:0];
					dir_wdata = ptmu_pkg::DIR_RESET;
				end
			end
			S_DIR: begin
				if (va_bad) begin
					res.status = ptmu_pkg::STATUS_VA_UNALIGN;
					finish     = 1'b1;
				end else if (func_q == ptmu_pkg::FUNC_MAP) begin
					if (pa_bad) begin
						res.status = ptmu_pkg::STATUS_PA_UNALIGN;
					end else if (!present && exhausted) begin
						res.status = ptmu_pkg::STATUS_EXHAUSTED;
					end else begin
						res.status          = ptmu_pkg::STATUS_OK;
						res.table_allocated = !present;
						res.entry_value     = pa_q | ptmu_pkg::ENTRY_FLAGS;
						claim               = !present && out_free;
						dir_we              = !present && out_free;
						tbl_we              = slot_ok && out_free;
					end
					finish = 1'b1;
				end else begin
					if (!present) begin
						res.status = ptmu_pkg::STATUS_NO_DIR;
						finish     = 1'b1;
					end else if (!slot_ok) begin
						res.status = ptmu_pkg::STATUS_NOT_MAPPED;
						finish     = 1'b1;
					end else begin
						tbl_re = 1'b1;
						go_tbl = 1'b1;
					end
				end
			end
			S_TBL: begin
				if (!tbl_rdata[0]) begin
					res.status = ptmu_pkg::STATUS_NOT_MAPPED;
				end else begin
					res.status      = ptmu_pkg::STATUS_OK;
					res.entry_value = {tbl_rdata[EW-1:1], 1'b0};
					tbl_we          = out_free;
					tbl_waddr       = tbl_addr_q;
					tbl_wdata       = {tbl_rdata[EW-1:1], 1'b0};
				end
				finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, clearing pass, table counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			taf_q       <= ptmu_pkg::TAF_RESET;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				taf_q <= cfg_wdata;
			end
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + TBL_AW'(1);
				if (clr_cnt_q == TBL_AW'(CLR_LAST)) begin
					clr_q <= 1'b0;
				end
			end
			if (claim) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (finish && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIR;
					end
				end
				S_DIR: begin
					if (go_tbl) begin
						state_q <= S_TBL;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TBL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tuser[0];
			va_q   <= s_tdata[EW-1:0];
			pa_q   <= s_tdata[2*EW-1:EW];
		end
		if (go_tbl) begin
			tbl_addr_q <= tbl_addr;
		end
		if (finish && out_free) begin
			out_q <= res;
		end
	end

endmodule

### rtl/page_table_map_unmap.sv
`timescale 1ns / 1ps
// Timing: the result item is registered after the directory read for a map or any request
// rejected at the directory read, and after the table read for an unmap that reaches the table.
// A new request is not accepted until the result of the current one is registered; the
// reads are on synchronous memories, and a stalled result holds the block.
// Reset: asynchronous, active low; a clearing pass then sweeps both memories, and no item
// is accepted during it.
// ----------------------------------------------------------------------------
// page_table_map_unmap
// Two-level page table updater: maps and unmaps 4 KiB pages in a 1024-entry
// directory and a store of page tables claimed in order.
// ----------------------------------------------------------------------------
module page_table_map_unmap #(
	parameter int unsigned NUM_TABLES = ptmu_pkg::NUM_TABLES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ptmu_pkg::S_TUSER_W-1:0]       s_tuser,   // [0] func
	input  logic [ptmu_pkg::S_TDATA_W-1:0]       s_tdata,   // [31:0] vaddr,
	                                                         // [63:32] paddr
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ptmu_pkg::M_TDATA_W-1:0]       m_tdata,   // [2:0] status,
	                                                         // [3] table_allocated,
	                                                         // [13:4] directory_index,
	                                                         // [45:14] entry_value, [47:46] 0
	input  logic                                 cfg_we,
	input  logic [ptmu_pkg::FRAME_W-1:0]         cfg_wdata  // table_area_frame
);

	localparam int unsigned SLOT_W    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int unsigned TBL_AW    = SLOT_W + ptmu_pkg::IDX_W;
	localparam int unsigned TBL_DEPTH = NUM_TABLES * ptmu_pkg::TBL_ENTRIES;
	localparam int unsigned CNT_W     = $clog2(NUM_TABLES + 1);

	logic                          dir_we;
	logic [ptmu_pkg::IDX_W-1:0]    dir_waddr;
	logic [ptmu_pkg::ENTRY_W-1:0]  dir_wdata;
	logic                          dir_re;
	logic [ptmu_pkg::IDX_W-1:0]    dir_raddr;
	logic [ptmu_pkg::ENTRY_W-1:0]  dir_rdata;
	logic                          tbl_we;
	logic [TBL_AW-1:0]             tbl_waddr;
	logic [ptmu_pkg::ENTRY_W-1:0]  tbl_wdata;
	logic                          tbl_re;
	logic [TBL_AW-1:0]             tbl_raddr;
	logic [ptmu_pkg::ENTRY_W-1:0]  tbl_rdata;

	// Sequencer
	ptmu_ctrl #(
		.NUM_TABLES (NUM_TABLES),
		.SLOT_W     (SLOT_W),
		.TBL_AW     (TBL_AW),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.dir_we    (dir_we),
		.dir_waddr (dir_waddr),
		.dir_wdata (dir_wdata),
		.dir_re    (dir_re),
		.dir_raddr (dir_raddr),
		.dir_rdata (dir_rdata),
		.tbl_we    (tbl_we),
		.tbl_waddr (tbl_waddr),
		.tbl_wdata (tbl_wdata),
		.tbl_re    (tbl_re),
		.tbl_raddr (tbl_raddr),
		.tbl_rdata (tbl_rdata)
	);

	// Page directory
	ptmu_ram #(
		.DEPTH (ptmu_pkg::TBL_ENTRIES),
		.AW    (ptmu_pkg::IDX_W),
		.DW    (ptmu_pkg::ENTRY_W)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (dir_re),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	// Page table store
	ptmu_ram #(
		.DEPTH (TBL_DEPTH),
		.AW    (TBL_AW),
		.DW    (ptmu_pkg::ENTRY_W)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

endmodule

### rtl/ptmu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmu_checker
// Port-level checks on the page table updater: result consistency, output
// hold under backpressure and the minimum spacing of accepted items.
// ----------------------------------------------------------------------------
module ptmu_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ptmu_pkg::M_TDATA_W-1:0] m_tdata
);

	ptmu_pkg::result_t res;

	assign res = m_tdata;

	// An error result claims nothing and reports a zero entry
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.status != ptmu_pkg::STATUS_OK)
		|-> (res.entry_value == '0) && !res.table_allocated)
		else $error("error result carries an entry or a claim");

	// A claimed table always comes with a present, writable entry
	a_alloc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.table_allocated
		|-> (res.status == ptmu_pkg::STATUS_OK) && (res.entry_value[1:0] == 2'b11))
		else $error("table claim without a successful map");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// One request at a time: no acceptance in the cycle after one
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

endmodule

bind page_table_map_unmap ptmu_checker u_ptmu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
